[rtl/ste_pkg.sv]
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types, codes and reset values for the sonar trigger/echo sequencer.
// ----------------------------------------------------------------------------
package ste_pkg;

    localparam int NUM_SONARS_DEF = 4;

    // item kinds
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_ECHO    = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_REARM_WINDOW    = 2'd0;
    localparam logic [1:0] REG_DEADLINE_OFFSET = 2'd1;
    localparam logic [1:0] REG_LOWER_WINDOW    = 2'd2;

    localparam int PADDR_W = 4;

    localparam logic [15:0] REARM_WINDOW_RST    = 16'd2000;
    localparam logic [15:0] DEADLINE_OFFSET_RST = 16'd20000;
    localparam logic [15:0] LOWER_WINDOW_RST    = 16'd5000;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    typedef struct packed {
        logic [15:0] rearm_window;
        logic [15:0] deadline_offset;
        logic [15:0] lower_window;
    } cfg_t;

    typedef struct packed {
        logic        armed;
        logic        pending_low;
        logic        trig;
        logic [15:0] deadline;
        logic [15:0] pulse_end;
    } seq_state_t;

    typedef struct packed {
        logic        trigger_level;
        logic        reset_pulse;
        logic        range_valid;
        logic [1:0]  range_sonar;
        logic [15:0] range_clocks;
    } result_t;

endpackage

[rtl/ste_step.sv]
// ----------------------------------------------------------------------------
// ste_step
// Next-state and result logic for one word: tick, echo or restart.
// ----------------------------------------------------------------------------
module ste_step #(
    parameter int NUM_SONARS = ste_pkg::NUM_SONARS_DEF,
    parameter int IDX_W      = (NUM_SONARS > 1) ? $clog2(NUM_SONARS) : 1
) (
    input  ste_pkg::cfg_t       cfg,
    input  ste_pkg::seq_state_t cur,
    input  logic [IDX_W-1:0]    cur_idx,
    input  logic [1:0]          func,
    input  logic [15:0]         timer_value,
    output ste_pkg::seq_state_t nxt,
    output logic [IDX_W-1:0]    nxt_idx,
    output ste_pkg::result_t    res
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SONARS - 1);

    ste_pkg::seq_state_t tk;
    logic [IDX_W-1:0]    tk_idx;
    logic [IDX_W+1:0]    idx_ext;
    logic [15:0]         since_dl;
    logic [15:0]         to_dl;
    logic [15:0]         echo_clk;
    logic                fire;

    assign since_dl = timer_value - cur.deadline;
    assign echo_clk = timer_value - cur.pulse_end;
    assign idx_ext  = {2'b00, cur_idx};

    // tick: re-arm, raise, then possibly lower in the same word
    always_comb begin
        tk       = cur;
        tk_idx   = cur_idx;
        if (!cur.armed && (since_dl < cfg.rearm_window)) begin
            tk.armed = 1'b1;
        end
        fire = tk.armed && !tk.pending_low;
        if (fire) begin
            tk.trig        = 1'b1;
            tk.pending_low = 1'b1;
            tk.deadline    = timer_value + cfg.deadline_offset;
            tk_idx         = (cur_idx == IDX_LAST) ? '0 : cur_idx + 1'b1;
        end
        to_dl = tk.deadline - timer_value;
        if (tk.armed && tk.pending_low && (to_dl != 16'd0) && (to_dl < cfg.lower_window)) begin
            tk.trig        = 1'b0;
            tk.armed       = 1'b0;
            tk.pulse_end   = timer_value;
            tk.pending_low = 1'b0;
        end
    end

    always_comb begin
        nxt     = cur;
        nxt_idx = cur_idx;
        res     = '0;
        unique case (func)
            ste_pkg::FUNC_TICK: begin
                nxt     = tk;
                nxt_idx = tk_idx;
            end
            ste_pkg::FUNC_ECHO: begin
                nxt.armed        = 1'b1;
                res.range_valid  = 1'b1;
                res.range_sonar  = idx_ext[1:0];
                res.range_clocks = echo_clk;
            end
            ste_pkg::FUNC_RESTART: begin
                nxt.armed       = 1'b1;
                nxt.pending_low = 1'b0;
                nxt_idx         = '0;
                res.reset_pulse = 1'b1;
            end
            default: begin
                // unused kind: no change
            end
        endcase
        res.trigger_level = nxt.trig;
    end

endmodule

[rtl/sonar_trigger_echo_sequencer.sv]
// ----------------------------------------------------------------------------
// sonar_trigger_echo_sequencer
// Round-robin ultrasonic ranging sequencer driven by timer-stamped words.
// ----------------------------------------------------------------------------
// One result word per input word, one word per cycle sustained while results
// are taken. Each word's work is a handful of 16-bit wrapping subtracts and
// compares in ste_step, sitting between the sequencer state and the result
// register. The input side is ready whenever the result register is empty
// or is being taken in the same cycle, so a stalled sink stops intake only
// while its result is held. Input: s_tuser carries the kind (0 tick,
// 1 echo falling edge, 2 restart, 3 no-op), s_tdata the 16-bit timer count.
// A tick may re-arm an idle trigger when the timer lies within rearm_window
// past the deadline, raise the trigger, set deadline = timer +
// deadline_offset and step the sonar index, then lower the trigger once
// 0 < deadline - timer < lower_window, stamping the pulse end time. An echo
// reports timer - pulse end for the current sonar and re-arms. A restart
// flags reset_pulse, re-arms, clears pending_low and the index, keeps trig.
// Registers (APB, write-only effect, readable): 0x0 rearm_window,
// 0x4 deadline_offset, 0x8 lower_window; write them only while idle.
// ----------------------------------------------------------------------------
module sonar_trigger_echo_sequencer #(
    parameter int NUM_SONARS = ste_pkg::NUM_SONARS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ste_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] timer_value
    input  logic [ste_pkg::S_TUSER_W-1:0] s_tuser,   // [1:0] func
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] trigger_level, [2:1] range_sonar, [18:3] range_clocks, [23:19] zero
    output logic [ste_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] reset_pulse, [1] range_valid
    output logic [ste_pkg::M_TUSER_W-1:0] m_tuser,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ste_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int IDX_W = (NUM_SONARS > 1) ? $clog2(NUM_SONARS) : 1;

    ste_pkg::cfg_t       cfg_reg;
    ste_pkg::seq_state_t st_reg, st_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    ste_pkg::result_t    res_next, res_reg;
    logic                m_tvalid_reg;
    logic                s_accept;
    logic                cfg_wr;
    logic [1:0]          reg_sel;

    // ---- configuration port ----
    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rearm_window    <= ste_pkg::REARM_WINDOW_RST;
            cfg_reg.deadline_offset <= ste_pkg::DEADLINE_OFFSET_RST;
            cfg_reg.lower_window    <= ste_pkg::LOWER_WINDOW_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                ste_pkg::REG_REARM_WINDOW:    cfg_reg.rearm_window    <= pwdata[15:0];
                ste_pkg::REG_DEADLINE_OFFSET: cfg_reg.deadline_offset <= pwdata[15:0];
                ste_pkg::REG_LOWER_WINDOW:    cfg_reg.lower_window    <= pwdata[15:0];
                default: begin
                    // unmapped: ignored
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            ste_pkg::REG_REARM_WINDOW:    prdata = {16'd0, cfg_reg.rearm_window};
            ste_pkg::REG_DEADLINE_OFFSET: prdata = {16'd0, cfg_reg.deadline_offset};
            ste_pkg::REG_LOWER_WINDOW:    prdata = {16'd0, cfg_reg.lower_window};
            default:                      prdata = 32'd0;
        endcase
    end

    // ---- word handshake: result register parts the two sides ----
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    ste_step #(
        .NUM_SONARS (NUM_SONARS),
        .IDX_W      (IDX_W)
    ) u_step (
        .cfg         (cfg_reg),
        .cur         (st_reg),
        .cur_idx     (idx_reg),
        .func        (s_tuser[1:0]),
        .timer_value (s_tdata[15:0]),
        .nxt         (st_next),
        .nxt_idx     (idx_next),
        .res         (res_next)
    );

    // sequencer state moves only on an accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.armed       <= 1'b1;
            st_reg.pending_low <= 1'b0;
            st_reg.trig        <= 1'b0;
            st_reg.deadline    <= 16'd0;
            st_reg.pulse_end   <= 16'd0;
            idx_reg            <= '0;
        end else if (s_accept) begin
            st_reg  <= st_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, res_reg.range_clocks, res_reg.range_sonar, res_reg.trigger_level};
    assign m_tuser  = {res_reg.range_valid, res_reg.reset_pulse};

endmodule

[rtl/ste_checker.sv]
// ----------------------------------------------------------------------------
// ste_checker
// Port-level checks on the sequencer's streams, bound to the top level.
// ----------------------------------------------------------------------------
module ste_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [ste_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ste_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [ste_pkg::M_TUSER_W-1:0] m_tuser
);

    // held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // empty result register never blocks intake
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // restart yields a reset pulse word with no range
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ste_pkg::FUNC_RESTART)
        |=> m_tvalid && m_tuser[0] && !m_tuser[1] && (m_tdata[18:1] == 18'd0))
        else $error("restart word not reported as reset pulse");

    // range fields zero unless a range is reported
    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> (m_tdata[23:1] == 23'd0))
        else $error("range fields set without range_valid");

endmodule

bind sonar_trigger_echo_sequencer ste_checker u_ste_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
